// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies c in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");

// a implies c after the delay given by n
`define ASSERT_DELAY(lbl, clk, rst, a, n, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##(n) (c)) \
    else $error("delayed check failed");

`endif

// ===== rtl/core/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants of the pinhole point projection unit.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int NumRegs     = 8;
  localparam int IdxW        = 3;
  localparam int CfgW        = 64;
  localparam int DivBits     = 48;
  localparam int FrontStages = 5;
  localparam int BackStages  = 2;
  localparam int Latency     = FrontStages + DivBits + BackStages;

  localparam logic signed [23:0] PixMax = 24'sh7FFFFF;
  localparam logic signed [23:0] PixMin = -24'sh800000;

  typedef enum logic [IdxW-1:0] {
    RegRot0      = 3'd0,
    RegRot1      = 3'd1,
    RegRot2      = 3'd2,
    RegTrans     = 3'd3,
    RegFocal     = 3'd4,
    RegPrincipal = 3'd5,
    RegDepthMode = 3'd6,
    RegViewport  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [23:0] pixel_x;
    logic signed [23:0] pixel_y;
    logic signed [19:0] depth;
    logic               visible;
    logic               divide_fault;
  } result_t;

  typedef struct packed {
    logic [2:0][2:0][15:0] rot;    // [axis][world component]
    logic [2:0][19:0]      trans;
    logic [23:0]           fx;
    logic [23:0]           fy;
    logic [23:0]           cx;
    logic [23:0]           cy;
    logic [19:0]           znear;
    logic [19:0]           zfar;
    logic                  persp;
    logic                  fwd;
    logic [15:0]           left;
    logic [15:0]           top;
    logic [15:0]           vw;
    logic [15:0]           vh;
  } cfg_t;

  // carried untouched through the divider chain
  typedef struct packed {
    logic signed [25:0] mz;
    logic               persp;
    logic               fault;
    logic               neg_x;
    logic               neg_y;
    logic               nonneg_x;
    logic               nonneg_y;
    logic signed [40:0] orth_x;
    logic signed [40:0] orth_y;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] nx;
    logic [47:0] ny;
    logic [25:0] rx;
    logic [25:0] ry;
    logic [47:0] qx;
    logic [47:0] qy;
    logic [25:0] dv;
    side_t       side;
  } div_t;

endpackage

// ===== rtl/core/ppp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppp_cfg_regs
// Configuration register file with decoded field view.
// ----------------------------------------------------------------------------
module ppp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  logic [ppp_pkg::IdxW-1:0]     idx,
  input  logic [ppp_pkg::CfgW-1:0]     data,
  output ppp_pkg::cfg_t                cfg
);

  logic [47:0] rot0, rot1, rot2, focal, principal;
  logic [59:0] trans;
  logic [41:0] depth_mode;
  logic [63:0] viewport;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot0       <= 48'd16384;
      rot1       <= 48'd1073741824;
      rot2       <= 48'd70368744177664;
      trans      <= 60'd0;
      focal      <= 48'd1374389616640;
      principal  <= 48'd1030792232960;
      depth_mode <= 42'd1367947083802;
      viewport   <= 64'd135110737600184320;
    end else if (wr) begin
      case (ppp_pkg::reg_idx_t'(idx))
        ppp_pkg::RegRot0:      rot0       <= data[47:0];
        ppp_pkg::RegRot1:      rot1       <= data[47:0];
        ppp_pkg::RegRot2:      rot2       <= data[47:0];
        ppp_pkg::RegTrans:     trans      <= data[59:0];
        ppp_pkg::RegFocal:     focal      <= data[47:0];
        ppp_pkg::RegPrincipal: principal  <= data[47:0];
        ppp_pkg::RegDepthMode: depth_mode <= data[41:0];
        ppp_pkg::RegViewport:  viewport   <= data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rot[0] = rot0;
    cfg.rot[1] = rot1;
    cfg.rot[2] = rot2;
    cfg.trans  = trans;
    cfg.fx     = focal[23:0];
    cfg.fy     = focal[47:24];
    cfg.cx     = principal[23:0];
    cfg.cy     = principal[47:24];
    cfg.znear  = depth_mode[19:0];
    cfg.zfar   = depth_mode[39:20];
    cfg.persp  = depth_mode[40];
    cfg.fwd    = depth_mode[41];
    cfg.left   = viewport[15:0];
    cfg.top    = viewport[31:16];
    cfg.vw     = viewport[47:32];
    cfg.vh     = viewport[63:48];
  end

endmodule

// ===== rtl/core/ppp_front.sv =====
// ----------------------------------------------------------------------------
// ppp_front
// Camera-frame transform, focal scaling and divider operand setup.
// ----------------------------------------------------------------------------
module ppp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  ppp_pkg::point_t pt,
  input  ppp_pkg::cfg_t   cfg,
  output ppp_pkg::div_t   dout
);

  logic                          v1, v2, v3, v4;
  logic signed [2:0][20:0]       d;
  logic signed [2:0][2:0][36:0]  prod;
  logic signed [2:0][24:0]       loc;
  logic signed [25:0]            mz;
  logic signed [48:0]            numx, numy;
  logic                          persp4;

  logic [2:0][19:0]              pv;
  logic signed [38:0]            acc [3];
  logic signed [38:0]            accr [3];

  always_comb begin
    pv[0] = pt.point_x;
    pv[1] = pt.point_y;
    pv[2] = pt.point_z;
    for (int a = 0; a < 3; a++) begin
      acc[a] = 39'($signed(prod[a][0])) + 39'($signed(prod[a][1])) +
               39'($signed(prod[a][2]));
      accr[a] = acc[a] + 39'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      dout.valid <= v4;
    end
    for (int j = 0; j < 3; j++) begin
      d[j] <= $signed({pv[j][19], pv[j]}) - $signed({cfg.trans[j][19], cfg.trans[j]});
    end
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        prod[a][j] <= 37'($signed(cfg.rot[a][j]) * $signed(d[j]));
      end
      // round half up to Q.8
      loc[a] <= accr[a][38:14];
    end
    mz     <= cfg.fwd ? 26'($signed(loc[2])) : -26'($signed(loc[2]));
    numx   <= 49'($signed(loc[0]) * $signed({1'b0, cfg.fx}));
    numy   <= 49'($signed(loc[1]) * $signed({1'b0, cfg.fy}));
    persp4 <= cfg.persp;

    dout.nx <= numx[48] ? 48'(-numx) : numx[47:0];
    dout.ny <= numy[48] ? 48'(-numy) : numy[47:0];
    dout.rx <= '0;
    dout.ry <= '0;
    dout.qx <= '0;
    dout.qy <= '0;
    dout.dv <= mz[25] ? 26'(-mz) : 26'(mz);
    dout.side.mz       <= mz;
    dout.side.persp    <= persp4;
    dout.side.fault    <= persp4 && (mz == 26'sd0);
    dout.side.neg_x    <= numx[48] ^ mz[25];
    dout.side.neg_y    <= numy[48] ^ mz[25];
    dout.side.nonneg_x <= !numx[48];
    dout.side.nonneg_y <= !numy[48];
    dout.side.orth_x   <= numx[48:8];
    dout.side.orth_y   <= numy[48:8];
  end

endmodule

// ===== rtl/core/ppp_div_cell.sv =====
// ----------------------------------------------------------------------------
// ppp_div_cell
// One restoring-division cell: retires one quotient bit of both lanes.
// ----------------------------------------------------------------------------
module ppp_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  ppp_pkg::div_t din,
  output ppp_pkg::div_t dout
);

  logic [26:0] tx, ty, sx, sy;
  logic        bx, by;

  always_comb begin
    tx = {din.rx, din.nx[47]};
    ty = {din.ry, din.ny[47]};
    sx = tx - {1'b0, din.dv};
    sy = ty - {1'b0, din.dv};
    bx = tx >= {1'b0, din.dv};
    by = ty >= {1'b0, din.dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.nx   <= {din.nx[46:0], 1'b0};
    dout.ny   <= {din.ny[46:0], 1'b0};
    dout.rx   <= bx ? sx[25:0] : tx[25:0];
    dout.ry   <= by ? sy[25:0] : ty[25:0];
    dout.qx   <= {din.qx[46:0], bx};
    dout.qy   <= {din.qy[46:0], by};
    dout.dv   <= din.dv;
    dout.side <= din.side;
  end

endmodule

// ===== rtl/core/ppp_back.sv =====
// ----------------------------------------------------------------------------
// ppp_back
// Sign fixup, principal point, view test and output saturation.
// ----------------------------------------------------------------------------
module ppp_back (
  input  logic             clk,
  input  logic             rst,
  input  ppp_pkg::div_t    din,
  input  ppp_pkg::cfg_t    cfg,
  output logic             done,
  output ppp_pkg::result_t result
);

  logic               v1;
  logic signed [49:0] px, py;
  logic signed [25:0] mz1;
  logic               fault1, nnx1, nny1;

  logic signed [49:0] qx, qy;
  logic signed [41:0] ix, iy;
  logic signed [49:0] pxr, pyr;
  logic signed [41:0] lo_x, hi_x, lo_y, hi_y;
  logic               vis;
  logic signed [23:0] satx, saty;
  logic signed [19:0] dep;

  always_comb begin
    qx = din.side.neg_x ? -$signed({2'b00, din.qx}) : $signed({2'b00, din.qx});
    qy = din.side.neg_y ? -$signed({2'b00, din.qy}) : $signed({2'b00, din.qy});

    // truncate toward zero
    pxr = px[49] ? px + 50'sd255 : px;
    pyr = py[49] ? py + 50'sd255 : py;
    ix  = pxr[49:8];
    iy  = pyr[49:8];
    lo_x = $signed({26'd0, cfg.left});
    hi_x = $signed(42'({1'b0, cfg.left} + {1'b0, cfg.vw}));
    lo_y = $signed({26'd0, cfg.top});
    hi_y = $signed(42'({1'b0, cfg.top} + {1'b0, cfg.vh}));
    vis = !fault1 && (ix >= lo_x) && (ix <= hi_x) && (iy >= lo_y) && (iy <= hi_y)
          && (mz1 >= 26'($signed(cfg.znear))) && (mz1 <= 26'($signed(cfg.zfar)));

    if (fault1) begin
      satx = nnx1 ? ppp_pkg::PixMax : ppp_pkg::PixMin;
      saty = nny1 ? ppp_pkg::PixMax : ppp_pkg::PixMin;
    end else begin
      satx = (px > 50'(ppp_pkg::PixMax)) ? ppp_pkg::PixMax :
             (px < 50'(ppp_pkg::PixMin)) ? ppp_pkg::PixMin : px[23:0];
      saty = (py > 50'(ppp_pkg::PixMax)) ? ppp_pkg::PixMax :
             (py < 50'(ppp_pkg::PixMin)) ? ppp_pkg::PixMin : py[23:0];
    end
    if (fault1) begin
      dep = '0;
    end else if (mz1 > 26'sd524287) begin
      dep = 20'sd524287;
    end else if (mz1 < -26'sd524288) begin
      dep = -20'sd524288;
    end else begin
      dep = mz1[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= din.valid;
      done <= v1;
    end
    if (din.side.persp) begin
      px <= qx + $signed({26'd0, cfg.cx});
      py <= qy + $signed({26'd0, cfg.cy});
    end else begin
      px <= 50'(din.side.orth_x) + $signed({26'd0, cfg.cx});
      py <= 50'(din.side.orth_y) + $signed({26'd0, cfg.cy});
    end
    mz1    <= din.side.mz;
    fault1 <= din.side.fault;
    nnx1   <= din.side.nonneg_x;
    nny1   <= din.side.nonneg_y;

    result.pixel_x      <= satx;
    result.pixel_y      <= saty;
    result.depth        <= dep;
    result.visible      <= vis;
    result.divide_fault <= fault1;
  end

endmodule

// ===== rtl/core/pinhole_point_projection_unit.sv =====
// ----------------------------------------------------------------------------
// pinhole_point_projection_unit
// Projects world points to pixel coordinates through a configured pinhole.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a word on point; it is taken at any edge with busy low.
//   busy never rises: one point may be taken every cycle.
//   Each result word appears on result for one cycle with done high,
//   after its point was taken and passed 5 transform stages, one
//   48-cell divider chain retiring one quotient bit per cell and 2 output
//   stages. Results leave in order, one per cycle at most.
//   The receiver cannot stall; done words must be captured when shown.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, ready is
//   always high. Write only while no points are in flight.
//   Reset (rst, synchronous) restores the default camera and empties the
//   pipeline; no done is raised for points in flight at reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pinhole_point_projection_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  ppp_pkg::point_t          point,
  output logic                     done,
  output ppp_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ppp_pkg::IdxW-1:0] cfg_index,
  input  logic [ppp_pkg::CfgW-1:0] cfg_data
);

  ppp_pkg::cfg_t cfg;
  ppp_pkg::div_t link [ppp_pkg::DivBits+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  ppp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wr   (cfg_valid && cfg_ready),
    .idx  (cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  ppp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (start && !busy),
    .pt   (point),
    .cfg  (cfg),
    .dout (link[0])
  );

  for (genvar i = 0; i < ppp_pkg::DivBits; i++) begin : g_cell
    ppp_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  ppp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .din    (link[ppp_pkg::DivBits]),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

  `ASSERT_DELAY(a_latency, clk, rst, start && !busy, ppp_pkg::Latency, done)
  `ASSERT_IMPL(a_fault_hidden, clk, rst, done && result.divide_fault,
    !result.visible && result.depth == 20'sd0)
  `ASSERT_IMPL(a_fault_sat, clk, rst, done && result.divide_fault,
    result.pixel_x == ppp_pkg::PixMax || result.pixel_x == ppp_pkg::PixMin)

endmodule

// ===== sim/tb_pinhole_point_projection_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pinhole_point_projection_unit
// Self-checking bench for the pinhole point projection unit: points are sent
// in random bursts under several camera setups, and every result word is
// compared with a bit-accurate projection computed in the bench.
// ----------------------------------------------------------------------------
module tb_pinhole_point_projection_unit;

  localparam int SettleCycles = ppp_pkg::Latency + 10;
  localparam int IdleLimit    = 20000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  ppp_pkg::point_t          point = '0;
  logic                     done;
  ppp_pkg::result_t         result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [ppp_pkg::IdxW-1:0] cfg_index = '0;
  logic [ppp_pkg::CfgW-1:0] cfg_data = '0;

  // camera registers as the bench believes them
  logic [63:0] cam_regs [ppp_pkg::NumRegs];
  int          idle_cycles = 0;

  always #6 clk = ~clk;

  pinhole_point_projection_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint sx(logic [63:0] v, int w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    v = v & m;
    if (v[w-1]) return longint'(v) - longint'(64'd1 << w);
    return longint'(v);
  endfunction

  function automatic longint floor_div_pow2(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic ppp_pkg::result_t project_point(ppp_pkg::point_t p);
    ppp_pkg::result_t r;
    longint  d[3], loc[3], acc, mz, nx, ny, px, py, ix, iy;
    longint  left, top, vw, vh, zn, zf;
    logic    persp, fwd, fault, vis;
    d[0] = longint'(p.point_x) - sx(cam_regs[ppp_pkg::RegTrans], 20);
    d[1] = longint'(p.point_y) - sx(cam_regs[ppp_pkg::RegTrans] >> 20, 20);
    d[2] = longint'(p.point_z) - sx(cam_regs[ppp_pkg::RegTrans] >> 40, 20);
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += sx(cam_regs[a] >> (16 * j), 16) * d[j];
      loc[a] = floor_div_pow2(acc + 8192, 14);
    end
    persp = cam_regs[ppp_pkg::RegDepthMode][40];
    fwd   = cam_regs[ppp_pkg::RegDepthMode][41];
    zn    = sx(cam_regs[ppp_pkg::RegDepthMode], 20);
    zf    = sx(cam_regs[ppp_pkg::RegDepthMode] >> 20, 20);
    mz    = fwd ? loc[2] : -loc[2];
    nx    = loc[0] * longint'(cam_regs[ppp_pkg::RegFocal][23:0]);
    ny    = loc[1] * longint'(cam_regs[ppp_pkg::RegFocal][47:24]);
    fault = 1'b0;
    if (persp) begin
      if (mz == 0) begin
        fault = 1'b1;
        px = nx >= 0 ? 8388607 : -8388608;
        py = ny >= 0 ? 8388607 : -8388608;
      end else begin
        // SV division truncates toward zero, as intended
        px = nx / mz + longint'(cam_regs[ppp_pkg::RegPrincipal][23:0]);
        py = ny / mz + longint'(cam_regs[ppp_pkg::RegPrincipal][47:24]);
      end
    end else begin
      px = floor_div_pow2(nx, 8) + longint'(cam_regs[ppp_pkg::RegPrincipal][23:0]);
      py = floor_div_pow2(ny, 8) + longint'(cam_regs[ppp_pkg::RegPrincipal][47:24]);
    end
    left = longint'(cam_regs[ppp_pkg::RegViewport][15:0]);
    top  = longint'(cam_regs[ppp_pkg::RegViewport][31:16]);
    vw   = longint'(cam_regs[ppp_pkg::RegViewport][47:32]);
    vh   = longint'(cam_regs[ppp_pkg::RegViewport][63:48]);
    ix = px / 256;
    iy = py / 256;
    vis = !fault && left <= ix && ix <= left + vw && top <= iy &&
          iy <= top + vh && mz >= zn && mz <= zf;
    r.pixel_x      = 24'(clip(px, -8388608, 8388607));
    r.pixel_y      = 24'(clip(py, -8388608, 8388607));
    r.depth        = 20'(clip(mz, -524288, 524287));
    r.visible      = vis;
    r.divide_fault = fault;
    return r;
  endfunction

  class projection_scoreboard;
    ppp_pkg::result_t pending[$];
    int               mismatches = 0;
    int               orphans = 0;

    function void note_point(ppp_pkg::result_t want);
      pending.push_back(want);
    endfunction

    function void check_result(ppp_pkg::result_t got);
      ppp_pkg::result_t want;
      if (pending.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10)
          $display("unexpected result word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.depth !== want.depth || got.visible !== want.visible ||
          got.divide_fault !== want.divide_fault) begin
        mismatches++;
        if (mismatches + orphans <= 10)
          $display("mismatch: exp px=%0d py=%0d z=%0d v=%b f=%b  got px=%0d py=%0d z=%0d v=%b f=%b",
                   want.pixel_x, want.pixel_y, want.depth, want.visible,
                   want.divide_fault, got.pixel_x, got.pixel_y, got.depth,
                   got.visible, got.divide_fault);
      end
    endfunction
  endclass

  projection_scoreboard board = new();

  // results cannot be held off, so take every done word
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(ppp_pkg::reg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ppp_pkg::RegTrans:     cam_regs[idx] = val & 64'hFFF_FFFF_FFFF_FFFF;
      ppp_pkg::RegDepthMode: cam_regs[idx] = val & 64'h3FF_FFFF_FFFF;
      ppp_pkg::RegViewport:  cam_regs[idx] = val;
      default:               cam_regs[idx] = val & 64'hFFFF_FFFF_FFFF;
    endcase
  endtask

  task automatic send_point(ppp_pkg::point_t p);
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_point(project_point(p));
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic ppp_pkg::point_t rand_point(int mode);
    ppp_pkg::point_t p;
    if (mode == 0) begin
      p.point_x = 20'($urandom);
      p.point_y = 20'($urandom);
      p.point_z = 20'($urandom);
    end else begin
      // points near the camera axis so many land in view
      p.point_x = 20'(int'($urandom_range(0, 8191)) - 4096);
      p.point_y = 20'(int'($urandom_range(0, 8191)) - 4096);
      p.point_z = 20'(int'($urandom_range(0, 200000)) - 100000);
    end
    return p;
  endfunction

  function automatic logic [63:0] rand_rot();
    logic [63:0] v;
    v = {$urandom, $urandom};
    // mostly small entries, sometimes the full Q1.14 range
    if ($urandom_range(0, 3) != 0) begin
      for (int j = 0; j < 3; j++)
        v[16*j +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    return v & 64'hFFFF_FFFF_FFFF;
  endfunction

  task automatic random_camera(int k);
    logic [63:0] dm;
    write_reg(ppp_pkg::RegRot0, rand_rot());
    write_reg(ppp_pkg::RegRot1, rand_rot());
    write_reg(ppp_pkg::RegRot2, rand_rot());
    write_reg(ppp_pkg::RegTrans, {$urandom, $urandom});
    write_reg(ppp_pkg::RegFocal, (k % 3 == 0) ? {$urandom, $urandom} :
              {16'd0, 24'($urandom_range(0, 2000) << 8), 24'($urandom_range(0, 2000) << 8)});
    write_reg(ppp_pkg::RegPrincipal, {$urandom, $urandom});
    dm = {$urandom, $urandom};
    if (k % 2 == 0) begin
      dm[19:0]  = 20'($urandom_range(0, 4096));
      dm[39:20] = 20'($urandom_range(100000, 524287));
    end
    write_reg(ppp_pkg::RegDepthMode, dm);
    write_reg(ppp_pkg::RegViewport,
              (k % 4 == 0) ? 64'hFFFF_FFFF_0000_0000 : {$urandom, $urandom});
  endtask

  task automatic random_phase(int count);
    int sent = 0;
    int burst;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_point(rand_point($urandom_range(0, 2) == 0 ? 0 : 1));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    cam_regs[0] = 64'd16384;
    cam_regs[1] = 64'd1073741824;
    cam_regs[2] = 64'd70368744177664;
    cam_regs[3] = 64'd0;
    cam_regs[4] = 64'd1374389616640;
    cam_regs[5] = 64'd1030792232960;
    cam_regs[6] = 64'd1367947083802;
    cam_regs[7] = 64'd135110737600184320;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default camera: extremes, on-axis (divide by zero), in view
    send_point('{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF});
    send_point('{-20'sh80000, -20'sh80000, -20'sh80000});
    send_point('{20'sh7FFFF, -20'sh80000, 20'sh0});
    send_point('{-20'sh80000, 20'sh7FFFF, 20'sh0});
    send_point('{20'sh0, 20'sh0, 20'sh0});
    send_point('{20'sh100, 20'sh100, -20'sh500});
    send_point('{-20'sh100, -20'sh100, -20'sh1000});
    send_point('{20'sh0, 20'sh0, -20'sh1A});
    send_point('{20'sh0, 20'sh0, -20'sh19});
    send_point('{20'sh0, 20'sh0, 20'sh100});
    drain();

    // forward-looking orthographic, near above far
    write_reg(ppp_pkg::RegDepthMode, {2'b10, 20'sd1000, 20'sd5000});
    send_point('{20'sh200, -20'sh200, 20'sh300});
    send_point('{-20'sh7, 20'sh7, -20'sh300});
    send_point('{20'sh7FFFF, -20'sh80000, 20'sh0});
    drain();
    write_reg(ppp_pkg::RegDepthMode, {2'b11, 20'sh7FFFF, -20'sh80000});
    write_reg(ppp_pkg::RegFocal, 64'hFFFF_FFFF_FFFF);
    write_reg(ppp_pkg::RegPrincipal, 64'hFFFF_FFFF_FFFF);
    send_point('{20'sh0, 20'sh0, 20'sh0});
    send_point('{20'sh1, -20'sh1, 20'sh1});
    send_point('{20'sh7FFFF, 20'sh7FFFF, -20'sh1});
    drain();

    for (int k = 0; k < 9; k++) begin
      random_camera(k);
      random_phase(200);
      drain();
    end
    // back to the default camera to finish
    write_reg(ppp_pkg::RegRot0, 64'd16384);
    write_reg(ppp_pkg::RegRot1, 64'd1073741824);
    write_reg(ppp_pkg::RegRot2, 64'd70368744177664);
    write_reg(ppp_pkg::RegTrans, 64'd0);
    write_reg(ppp_pkg::RegFocal, 64'd1374389616640);
    write_reg(ppp_pkg::RegPrincipal, 64'd1030792232960);
    write_reg(ppp_pkg::RegDepthMode, 64'd1367947083802);
    write_reg(ppp_pkg::RegViewport, 64'd135110737600184320);
    random_phase(50);
    drain();

    if (board.mismatches == 0 && board.orphans == 0 && board.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_cfg_regs.sv
rtl/core/ppp_front.sv
rtl/core/ppp_div_cell.sv
rtl/core/ppp_back.sv
rtl/core/pinhole_point_projection_unit.sv
sim/tb_pinhole_point_projection_unit.sv
